/* rtl/core/line_rasterizer_core_macros.svh */
// ----------------------------------------------------------------------------
// line_rasterizer_core_macros.svh
// Assertion macros shared by the line rasterizer core modules.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_CORE_MACROS_SVH
`define LINE_RASTERIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Checked property, disabled while reset is asserted (active-low reset).
`define LR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("line_rasterizer_core assertion failed");

// Checked property, also evaluated during reset.
`define LR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("line_rasterizer_core assertion failed");

`else

`define LR_ASSERT(lbl, clk, rst_n, prop)
`define LR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/core/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants, types and helpers of the line rasterizer core.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int GRID_SIDE = 64;
    localparam int COORD_W   = 6;
    // signed error term: holds -(GRID_SIDE-1) .. GRID_SIDE-1 with headroom
    localparam int ERR_W     = COORD_W + 2;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIDE - 1);

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [ERR_W-1:0] t_err;

    // One classified segment, ready for stepping.
    typedef struct packed {
        logic   steep;     // y is the major axis
        logic   step_neg;  // minor coordinate decreases
        t_coord maj0;      // first major coordinate
        t_coord min0;      // first minor coordinate
        t_coord dmaj;      // major span
        t_coord dmin;      // minor span
    } t_seg_cmd;

    function automatic t_coord clamp_coord(input t_coord v);
        clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic t_coord span_of(input t_coord a, input t_coord b);
        span_of = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* rtl/core/lr_front.sv */
// ----------------------------------------------------------------------------
// lr_front
// Classifies an incoming segment: clamps endpoints, picks the major axis,
// orders the endpoints along it and computes spans and step direction.
// ----------------------------------------------------------------------------
module lr_front (
    input  lr_pkg::t_coord   i_start_x,
    input  lr_pkg::t_coord   i_start_y,
    input  lr_pkg::t_coord   i_end_x,
    input  lr_pkg::t_coord   i_end_y,
    output lr_pkg::t_seg_cmd o_cmd
);
    import lr_pkg::*;

    t_coord ax, ay, bx, by;
    t_coord maj_a, min_a, maj_b, min_b;
    t_coord maj0, min0, maj1, min1;
    logic   steep;

    always_comb begin
        ax = clamp_coord(i_start_x);
        ay = clamp_coord(i_start_y);
        bx = clamp_coord(i_end_x);
        by = clamp_coord(i_end_y);

        // equal spans stay x-major
        steep = span_of(by, ay) > span_of(bx, ax);

        maj_a = steep ? ay : ax;
        min_a = steep ? ax : ay;
        maj_b = steep ? by : bx;
        min_b = steep ? bx : by;

        if (maj_a > maj_b) begin
            maj0 = maj_b;
            min0 = min_b;
            maj1 = maj_a;
            min1 = min_a;
        end else begin
            maj0 = maj_a;
            min0 = min_a;
            maj1 = maj_b;
            min1 = min_b;
        end

        o_cmd.steep    = steep;
        o_cmd.step_neg = (min1 < min0);
        o_cmd.maj0     = maj0;
        o_cmd.min0     = min0;
        o_cmd.dmaj     = maj1 - maj0;
        o_cmd.dmin     = span_of(min1, min0);
    end

endmodule

/* rtl/core/lr_queue.sv */
// ----------------------------------------------------------------------------
// lr_queue
// Two-entry command queue between the classifier and the stepper.
// ----------------------------------------------------------------------------
module lr_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  lr_pkg::t_seg_cmd i_push_cmd,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output lr_pkg::t_seg_cmd o_pop_cmd
);
    import lr_pkg::*;

    `include "line_rasterizer_core_macros.svh"

    localparam logic [1:0] DEPTH = 2'd2;

    t_seg_cmd   r_slot [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_push_ready = (r_count != DEPTH);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    `LR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= DEPTH)
    `LR_ASSERT(a_ptr_match, i_clk, i_rst_n, ((r_count == 2'd0) || (r_count == DEPTH)) |-> (r_wr_ptr == r_rd_ptr))

endmodule

/* rtl/core/lr_back.sv */
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: takes one classified segment at a time and emits one
// pixel per cycle into a registered output stage while the output is taken.
// ----------------------------------------------------------------------------
module lr_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    output logic             o_cmd_ready,
    input  lr_pkg::t_seg_cmd i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output lr_pkg::t_coord   o_pixel_x,
    output lr_pkg::t_coord   o_pixel_y,
    output logic             o_last_pixel
);
    import lr_pkg::*;

    `include "line_rasterizer_core_macros.svh"

    logic     r_busy, n_busy;
    t_seg_cmd r_cmd;
    t_coord   r_k;
    t_coord   r_minor;
    t_err     r_err;
    logic     r_out_valid;
    t_coord   r_px, r_py;
    logic     r_last;

    logic     step_en, load_en, last_step;
    t_coord   major;
    t_err     err_sub;
    t_err     n_err;
    t_coord   n_minor;

    assign o_cmd_ready = !r_busy;
    assign load_en     = !r_busy && i_cmd_valid;
    assign step_en     = r_busy && (!r_out_valid || i_ready);

    always_comb begin
        major     = r_cmd.maj0 + r_k;
        last_step = (r_k == r_cmd.dmaj);
        err_sub   = r_err - t_err'({2'b00, r_cmd.dmin});
        n_err     = err_sub;
        n_minor   = r_minor;
        if (err_sub < 0) begin
            n_minor = r_cmd.step_neg ? (r_minor - 1'b1) : (r_minor + 1'b1);
            n_err   = err_sub + t_err'({2'b00, r_cmd.dmaj});
        end
        n_busy = r_busy;
        if (load_en) begin
            n_busy = 1'b1;
        end else if (step_en && last_step) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (step_en) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_cmd   <= i_cmd;
            r_k     <= '0;
            r_minor <= i_cmd.min0;
            r_err   <= t_err'({2'b00, i_cmd.dmaj >> 1});
        end else if (step_en) begin
            r_k     <= r_k + 1'b1;
            r_minor <= n_minor;
            r_err   <= n_err;
        end
        if (step_en) begin
            r_px   <= r_cmd.steep ? r_minor : major;
            r_py   <= r_cmd.steep ? major : r_minor;
            r_last <= last_step;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_pixel_x    = r_px;
    assign o_pixel_y    = r_py;
    assign o_last_pixel = r_last;

    `LR_ASSERT(a_k_in_span, i_clk, i_rst_n, r_busy |-> (r_k <= r_cmd.dmaj))
    `LR_ASSERT(a_err_nonneg, i_clk, i_rst_n, r_busy |-> (r_err >= 0))
    `LR_ASSERT(a_last_ends_seg, i_clk, i_rst_n, (step_en && last_step) |=> (!r_busy && r_out_valid && r_last))

endmodule

/* rtl/core/line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line rasterizer: segment in, one pixel per unstalled cycle out.
// ----------------------------------------------------------------------------
// A segment is classified combinationally on acceptance and placed in a
// two-entry queue; the stepper then emits its pixels in ascending order of
// the major coordinate, one per clock while the output is taken, with the
// final pixel flagged by o_last_pixel. A segment with major span d yields
// d+1 pixels; the stepper loads the segment first and then steps its
// pixels one at a time, and it takes no new segment until the final pixel
// of the current one has been stepped. Coordinates above the edge of the
// 64x64 grid are clamped to it. Up to two segments are held while the
// stepper is busy.
module line_rasterizer_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lr_pkg::t_coord i_start_x,
    input  lr_pkg::t_coord i_start_y,
    input  lr_pkg::t_coord i_end_x,
    input  lr_pkg::t_coord i_end_y,
    output logic           o_valid,
    input  logic           i_ready,
    output lr_pkg::t_coord o_pixel_x,
    output lr_pkg::t_coord o_pixel_y,
    output logic           o_last_pixel
);
    import lr_pkg::*;

    t_seg_cmd front_cmd;
    t_seg_cmd q_cmd;
    logic     q_valid;
    logic     q_ready;

    lr_front u_front (
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_end_x   (i_end_x),
        .i_end_y   (i_end_y),
        .o_cmd     (front_cmd)
    );

    lr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_valid),
        .o_push_ready (o_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    lr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .o_cmd_ready  (q_ready),
        .i_cmd        (q_cmd),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_pixel (o_last_pixel)
    );

endmodule
